/* sv/crlf_pkg.sv */
// ----------------------------------------------------------------------------
// crlf_pkg: shared types and constants
// Character codes, register indexes and the per-word step result passed
// from the conversion logic to the top level.
// ----------------------------------------------------------------------------
package crlf_pkg;

  // character codes
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_DOT = 8'h2E;

  // configuration register indexes
  localparam logic REG_DIRECTION = 1'b0;
  localparam logic REG_DOT_MODE  = 1'b1;

  // direction codes
  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  // outcome of one input word: up to two output words and the next flags
  typedef struct packed {
    logic [1:0] count;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic       cr_pending_next;
    logic       line_start_next;
  } step_t;

endpackage

/* sv/crlf_dot_stuffing_filter.sv */
// ----------------------------------------------------------------------------
// crlf_dot_stuffing_filter: line ending converter with dot stuffing
// Byte stream filter converting LF to CRLF or back, with optional
// doubling or removal of a dot that starts a line.
// ----------------------------------------------------------------------------
// Each input word is a byte and gives zero, one or two output words; the
// last output word of a byte carries last. An input word sits in one
// register while the conversion logic feeds the result register one word
// per cycle when the result register is free; the byte leaves with its
// last output word, or at once if it gives none. With a free output side
// the sustained rate is one byte per cycle for plain text. A new byte is
// taken in the cycle the previous one finishes. Mode registers are to be
// written only while the block is idle; the block does not enforce this.
// A CR held back in decode mode at the end of a stream stays held.
module crlf_dot_stuffing_filter (
  input  logic       clk,
  input  logic       rst,
  // configuration
  input  logic       cfg_write,
  input  logic       cfg_index,
  input  logic       cfg_data,
  // input channel
  input  logic       data_valid,
  output logic       data_stall,
  input  logic [7:0] data_byte,
  // result channel
  output logic       result_valid,
  input  logic       result_stall,
  output logic [7:0] out_byte,
  output logic       last
);
  import crlf_pkg::*;

  logic       direction;
  logic       dot_mode;
  logic       cr_pending;
  logic       line_start;
  logic       in_full;
  logic [7:0] in_byte;
  logic       phase;
  step_t      step;
  logic       out_free;
  logic       emit;
  logic       emit_last;
  logic [7:0] emit_byte;
  logic       consume;
  logic       accept;

  // mode registers
  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= DIR_ENCODE;
      dot_mode  <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DIRECTION: direction <= cfg_data;
        REG_DOT_MODE:  dot_mode  <= cfg_data;
        default:       ;
      endcase
    end
  end

  // conversion logic
  crlf_step u_step (
    .direction  (direction),
    .dot_mode   (dot_mode),
    .cr_pending (cr_pending),
    .line_start (line_start),
    .data_byte  (in_byte),
    .step       (step)
  );

  // sequencing of the one or two output words
  assign emit_last = (step.count == 2'd1) || phase;
  assign emit_byte = phase ? step.byte1 : step.byte0;
  assign emit      = in_full && (step.count != 2'd0) && out_free;
  assign consume   = in_full && ((step.count == 2'd0) || (out_free && emit_last));
  assign data_stall = in_full && !consume;
  assign accept    = data_valid && !data_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept || consume) begin
      in_full <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_byte <= data_byte;
    end
  end

  // word phase within the current byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
    end else if (consume) begin
      phase <= 1'b0;
    end else if (emit) begin
      phase <= 1'b1;
    end
  end

  // stream flags, updated as each byte completes
  always_ff @(posedge clk) begin
    if (rst) begin
      cr_pending <= 1'b0;
      line_start <= 1'b1;
    end else if (consume) begin
      cr_pending <= step.cr_pending_next;
      line_start <= step.line_start_next;
    end
  end

  // result register
  crlf_out_reg u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (emit),
    .load_byte    (emit_byte),
    .load_last    (emit_last),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .out_byte     (out_byte),
    .last         (last),
    .free         (out_free)
  );

  // second word only exists for a held byte that expands to two
  a_phase_two: assert property (@(posedge clk) disable iff (rst)
    phase |-> (in_full && step.count == 2'd2))
    else $error("second word phase without a two-word byte");

  // an empty input register never stalls the input side
  a_no_stall_empty: assert property (@(posedge clk) disable iff (rst)
    !in_full |-> !data_stall)
    else $error("input stalled with empty input register");

  // a completed byte leaves the phase clear
  a_phase_clear: assert property (@(posedge clk) disable iff (rst)
    consume |=> !phase)
    else $error("phase not cleared after byte completed");

  // reset puts the stream at a line start with no CR held and the input register empty
  a_reset_flags: assert property (@(posedge clk)
    rst |=> (line_start && !cr_pending && !in_full))
    else $error("flags wrong after reset");

endmodule

/* sv/crlf_step.sv */
// ----------------------------------------------------------------------------
// crlf_step: conversion logic for one word
// Works out the output words and the next flag values for one input
// byte, given the current flags and mode registers.
// ----------------------------------------------------------------------------
module crlf_step (
  input  logic           direction,
  input  logic           dot_mode,
  input  logic           cr_pending,
  input  logic           line_start,
  input  logic [7:0]     data_byte,
  output crlf_pkg::step_t step
);
  import crlf_pkg::*;

  logic is_cr;
  logic is_lf;
  logic lead_dot;

  assign is_cr    = (data_byte == CH_CR);
  assign is_lf    = (data_byte == CH_LF);
  assign lead_dot = dot_mode && (data_byte == CH_DOT) && line_start;

  always_comb begin
    step.count           = 2'd1;
    step.byte0           = data_byte;
    step.byte1           = data_byte;
    step.cr_pending_next = 1'b0;
    step.line_start_next = 1'b0;
    if (direction == DIR_ENCODE) begin
      if (is_cr) begin
        // CR passes through, remembered for a following LF
        step.cr_pending_next = 1'b1;
        step.line_start_next = line_start;
      end else if (is_lf) begin
        // bare LF gets a CR in front
        step.line_start_next = 1'b1;
        if (!cr_pending) begin
          step.count = 2'd2;
          step.byte0 = CH_CR;
        end
      end else if (lead_dot) begin
        // dot at line start is doubled
        step.count = 2'd2;
      end
    end else begin
      if (is_cr) begin
        // hold the new CR, release an older one
        step.count           = cr_pending ? 2'd1 : 2'd0;
        step.byte0           = CH_CR;
        step.cr_pending_next = 1'b1;
      end else if (cr_pending && is_lf) begin
        // CR LF collapses to LF and starts a line
        step.line_start_next = 1'b1;
      end else if (cr_pending) begin
        // held CR goes out ahead of this byte, unless the byte is a dropped dot
        step.byte0 = CH_CR;
        step.count = lead_dot ? 2'd1 : 2'd2;
      end else begin
        step.count = lead_dot ? 2'd0 : 2'd1;
      end
    end
  end

endmodule

/* sv/crlf_out_reg.sv */
// ----------------------------------------------------------------------------
// crlf_out_reg: result register
// Holds one output word until the downstream side takes it, so the
// conversion logic can load a new word in the cycle the old one leaves.
// ----------------------------------------------------------------------------
module crlf_out_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  logic [7:0] load_byte,
  input  logic       load_last,
  input  logic       result_stall,
  output logic       result_valid,
  output logic [7:0] out_byte,
  output logic       last,
  output logic       free
);

  // register is free when empty or being drained this cycle
  assign free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (free) begin
      result_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      out_byte <= load_byte;
      last     <= load_last;
    end
  end

endmodule
